@@ src/cdm_pkg.sv @@
package cdm_pkg;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 18;
    localparam int ACC_W  = 18;
    localparam int CFG_W  = 15;
    localparam int IDX_W  = 2;
    localparam int DIG_W  = 2;

    localparam logic [IDX_W-1:0] REG_MAX_OUTPUT     = 2'd0;
    localparam logic [IDX_W-1:0] REG_STOP_THRESHOLD = 2'd1;
    localparam logic [IDX_W-1:0] REG_STOP_ALPHA     = 2'd2;

    localparam logic [CFG_W-1:0] MAX_OUTPUT_RESET     = 15'd16384;
    localparam logic [CFG_W-1:0] STOP_THRESHOLD_RESET = 15'd3277;
    localparam logic [CFG_W-1:0] STOP_ALPHA_RESET     = 15'd1638;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;

    typedef logic signed [IN_W-1:0]  t_in_val;
    typedef logic signed [OUT_W-1:0] t_out_val;
    typedef logic [CFG_W-1:0]        t_cfg_val;

endpackage

@@ src/curvature_drive_mixer.sv @@
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_ready | i_speed, i_rotation, i_quick_turn
// out     | output    | o_out_valid/i_out_ready | o_left_drive, o_right_drive
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction at a time: from input accept to result it makes two passes through
// the radix-4 serial multipliers (one digit per cycle), in S_FILT or S_NORM and then
// in S_SIDE/S_OUT. Quick turn without accumulator feed skips the first pass.
// Reset (synchronous, active low) clears the accumulator and loads register defaults.
// A stalled result waits in the output register while the next transaction runs;
// that one then holds its products in S_OUT until the output register is free.
module curvature_drive_mixer
    import cdm_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic signed [IN_W-1:0] i_speed,
    input  logic signed [IN_W-1:0] i_rotation,
    input  logic             i_quick_turn,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic signed [OUT_W-1:0] o_left_drive,
    output logic signed [OUT_W-1:0] o_right_drive,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int SW   = 20;
    localparam int MAW  = SW;
    localparam int MBW0 = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
    localparam int MBW  = MBW0 + (MBW0 % 2);
    localparam int PW   = MAW + MBW;
    localparam int RW   = PW + 2;
    localparam int CW   = (SW + 2 > FRAC_BITS + 3) ? SW + 2 : FRAC_BITS + 3;

    localparam logic signed [CW-1:0]  C_ONE     = CW'(1) << FRAC_BITS;
    localparam logic signed [CW-1:0]  C_NEG_ONE = -C_ONE;
    localparam logic signed [MBW-1:0] B_ONE     = MBW'(1) << FRAC_BITS;
    localparam logic signed [RW-1:0]  R_HALF    = RW'(1) << (FRAC_BITS - 1);
    localparam logic signed [RW-1:0]  R_MAX     = RW'(OUT_MAX);
    localparam logic signed [RW-1:0]  R_MIN     = RW'(OUT_MIN);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_FILT = 3'd2;
    localparam logic [2:0] S_NORM = 3'd3;
    localparam logic [2:0] S_SIDE = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    function automatic t_in_val clamp_one(input t_in_val v);
        logic signed [CW-1:0] w;
        w = CW'(v);
        if (w < C_NEG_ONE) begin
            w = C_NEG_ONE;
        end else if (w > C_ONE) begin
            w = C_ONE;
        end
        return w[IN_W-1:0];
    endfunction

    // round to nearest, ties up, then back to Q.FRAC_BITS
    function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] x);
        return (x + R_HALF) >>> FRAC_BITS;
    endfunction

    function automatic t_out_val sat_rnd(input logic signed [RW-1:0] x);
        logic signed [RW-1:0] y;
        y = rnd(x);
        if (y > R_MAX) begin
            return OUT_MAX;
        end else if (y < R_MIN) begin
            return OUT_MIN;
        end
        return y[OUT_W-1:0];
    endfunction

    logic [2:0]              r_state;
    logic                    r_out_valid;
    t_cfg_val                r_max;
    t_cfg_val                r_thr;
    t_cfg_val                r_alpha;
    logic signed [ACC_W-1:0] r_acc;
    t_in_val                 r_spd;
    t_in_val                 r_rot;
    logic                    r_quick;
    logic signed [SW-1:0]    r_ang;
    t_out_val                r_left;
    t_out_val                r_right;

    logic                    w_in_acc;
    logic [IN_W:0]           w_abs_spd;
    logic                    w_feed;
    logic                    w_out_free;
    logic                    w_load;
    logic signed [CW-1:0]    w_l0;
    logic signed [CW-1:0]    w_r0;
    logic signed [CW-1:0]    w_l1;
    logic signed [CW-1:0]    w_r1;
    logic signed [CW-1:0]    w_acc_x;
    logic signed [ACC_W-1:0] w_acc_decay;
    logic signed [RW-1:0]    w_norm_rnd;

    logic                    w_start0;
    logic                    w_start1;
    logic signed [MAW-1:0]   w_a0;
    logic signed [MAW-1:0]   w_a1;
    logic [MBW-1:0]          w_b0;
    logic [MBW-1:0]          w_b1;
    logic                    w_busy0;
    logic                    w_busy1;
    logic signed [PW-1:0]    w_p0;
    logic signed [PW-1:0]    w_p1;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load     = (r_state == S_OUT) && !w_busy0 && w_out_free;

    always_comb begin
        w_abs_spd = r_spd[IN_W-1] ? -((IN_W+1)'(r_spd)) : (IN_W+1)'(r_spd);
        w_feed    = r_quick && (w_abs_spd < (IN_W+1)'(r_thr));
    end

    // side values; quick turn moves the excess of an overpowered side across
    always_comb begin
        w_l0 = CW'(r_spd) + CW'(r_ang);
        w_r0 = CW'(r_spd) - CW'(r_ang);
        w_l1 = w_l0;
        w_r1 = w_r0;
        if (r_quick) begin
            if (w_l0 > C_ONE) begin
                w_r1 = w_r0 - (w_l0 - C_ONE);
                w_l1 = C_ONE;
            end else if (w_r0 > C_ONE) begin
                w_l1 = w_l0 - (w_r0 - C_ONE);
                w_r1 = C_ONE;
            end else if (w_l0 < C_NEG_ONE) begin
                w_r1 = w_r0 - (w_l0 + C_ONE);
                w_l1 = C_NEG_ONE;
            end else if (w_r0 < C_NEG_ONE) begin
                w_l1 = w_l0 - (w_r0 + C_ONE);
                w_r1 = C_NEG_ONE;
            end
        end
    end

    always_comb begin
        w_acc_x = CW'(r_acc);
        if (w_acc_x > C_ONE) begin
            w_acc_decay = ACC_W'(w_acc_x - C_ONE);
        end else if (w_acc_x < C_NEG_ONE) begin
            w_acc_decay = ACC_W'(w_acc_x + C_ONE);
        end else begin
            w_acc_decay = '0;
        end
        w_norm_rnd = rnd(RW'(w_p0));
    end

    always_comb begin
        w_start0 = 1'b0;
        w_start1 = 1'b0;
        w_a0 = '0;
        w_a1 = '0;
        w_b0 = '0;
        w_b1 = '0;
        case (r_state)
            S_PREP: begin
                if (w_feed) begin
                    w_start0 = 1'b1;
                    w_start1 = 1'b1;
                    w_a0 = MAW'(r_acc);
                    w_b0 = B_ONE - MBW'(r_alpha);
                    w_a1 = MAW'(r_rot) <<< 1;
                    w_b1 = MBW'(r_alpha);
                end else if (!r_quick) begin
                    w_start0 = 1'b1;
                    w_a0 = MAW'(r_rot);
                    w_b0 = MBW'(w_abs_spd);
                end
            end
            S_SIDE: begin
                w_start0 = 1'b1;
                w_start1 = 1'b1;
                w_a0 = MAW'(w_l1);
                w_a1 = MAW'(-w_r1);
                w_b0 = MBW'(r_max);
                w_b1 = MBW'(r_max);
            end
            default: begin
            end
        endcase
    end

    cdm_serial_mul #(
        .A_W(MAW),
        .B_W(MBW)
    ) u_mul0 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start0),
        .i_a    (w_a0),
        .i_b    (w_b0),
        .o_busy (w_busy0),
        .o_prod (w_p0)
    );

    cdm_serial_mul #(
        .A_W(MAW),
        .B_W(MBW)
    ) u_mul1 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start1),
        .i_a    (w_a1),
        .i_b    (w_b1),
        .o_busy (w_busy1),
        .o_prod (w_p1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max       <= MAX_OUTPUT_RESET;
            r_thr       <= STOP_THRESHOLD_RESET;
            r_alpha     <= STOP_ALPHA_RESET;
            r_acc       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_OUTPUT:     r_max   <= i_cfg_data;
                    REG_STOP_THRESHOLD: r_thr   <= i_cfg_data;
                    REG_STOP_ALPHA:     r_alpha <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // a new result may replace the one taken in the same cycle
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (w_feed) begin
                        r_state <= S_FILT;
                    end else if (r_quick) begin
                        r_state <= S_SIDE;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_FILT: begin
                    if (!w_busy0) begin
                        r_acc   <= sat_rnd(RW'(w_p0) + RW'(w_p1));
                        r_state <= S_SIDE;
                    end
                end
                S_NORM: begin
                    if (!w_busy0) begin
                        r_acc   <= w_acc_decay;
                        r_state <= S_SIDE;
                    end
                end
                S_SIDE: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_spd   <= clamp_one(i_speed);
            r_rot   <= clamp_one(i_rotation);
            r_quick <= i_quick_turn;
        end
        if (r_state == S_PREP) begin
            r_ang <= SW'(r_rot);
        end
        if (r_state == S_NORM && !w_busy0) begin
            r_ang <= SW'(w_norm_rnd) - SW'(r_acc);
        end
        if (w_load) begin
            r_left  <= sat_rnd(RW'(w_p0));
            r_right <= sat_rnd(RW'(w_p1));
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input accepted while a transaction is in flight");

    a_ready_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!w_busy0 && !w_busy1))
        else $error("multiplier busy while idle");

    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy1 |-> w_busy0)
        else $error("second multiplier running alone");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_left)))
        else $error("pending result overwritten");

endmodule

@@ src/cdm_serial_mul.sv @@
module cdm_serial_mul
    import cdm_pkg::*;
#(
    parameter int A_W = 20,
    parameter int B_W = 18
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [A_W-1:0]     i_a,
    input  logic [B_W-1:0]            i_b,
    output logic                      o_busy,
    output logic signed [A_W+B_W-1:0] o_prod
);

    // signed multiplicand times signed multiplier, radix-4, LSB digit first.
    // Low product bits shift into the multiplier register as its digits retire.
    localparam int STEPS = B_W / DIG_W;
    localparam int H_W   = A_W + 3;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic signed [A_W-1:0] r_a;
    logic signed [H_W-1:0] r_hi;
    logic [B_W-1:0]        r_b;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;

    logic                  w_last;
    logic signed [H_W-1:0] w_a1;
    logic signed [H_W-1:0] w_a2;
    logic signed [H_W-1:0] w_t1;
    logic signed [H_W-1:0] w_t2;
    logic signed [H_W-1:0] w_sum;

    assign w_last = (r_cnt == CNT_W'(1));
    assign w_a1   = H_W'(r_a);
    assign w_a2   = w_a1 <<< 1;

    always_comb begin
        w_t1 = r_b[0] ? w_a1 : '0;
        // top digit carries the sign bit of the multiplier (weight -2)
        if (r_b[1]) begin
            w_t2 = w_last ? -w_a2 : w_a2;
        end else begin
            w_t2 = '0;
        end
        w_sum = r_hi + w_t1 + w_t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_hi <= '0;
        end else if (r_busy) begin
            r_hi <= w_sum >>> DIG_W;
            r_b  <= {w_sum[DIG_W-1:0], r_b[B_W-1:DIG_W]};
        end
    end

    assign o_busy = r_busy;
    assign o_prod = {r_hi[A_W-1:0], r_b};

endmodule
